// ===== hdl/are_pkg.sv =====
`timescale 1ns / 1ps
package are_pkg;
    localparam int CNT_W = 17;
    localparam int WORD_W = 64;
    localparam logic [WORD_W-1:0] TOP_LIMIT = 64'h0100_0000_0000_0000;
    localparam logic [WORD_W-1:0] BOTTOM_LIMIT = 64'h0001_0000_0000_0000;
    localparam int MAX_BYTES = 8;

    typedef enum logic [1:0] {
        CMD_ENCODE = 2'd0,
        CMD_FLUSH  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_CLR_WR,
        OP_RD_LO,
        OP_RD_HI,
        OP_RD_TOT,
        OP_DIV_START,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_RENORM,
        OP_FLUSH_BYTE,
        OP_UPD_RD,
        OP_UPD_WR,
        OP_HALVE_RD,
        OP_HALVE_WR,
        OP_CODER_RESET
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [8:0] addr;
        logic       last_flag;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic renorm_go;
        logic total_full;
        logic prev_ge_tot;
    } dp_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD_LO,
        ST_RD_HI,
        ST_RD_TOT,
        ST_WAIT_TOT,
        ST_DIV,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_RENORM_CHK,
        ST_RENORM_OUT,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_TOT_RD,
        ST_TOT_WAIT,
        ST_HALVE_RD,
        ST_HALVE_WR,
        ST_FLUSH_OUT
    } state_t;
endpackage

// ===== hdl/are_ram.sv =====
`timescale 1ns / 1ps
module are_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 257
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/are_datapath.sv =====
`timescale 1ns / 1ps
module are_datapath
    import are_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  dp_cmd_t    cmd,
    output dp_stat_t   stat,
    output logic [7:0] byte_out
);
    logic [CNT_W-1:0] rdata;
    logic             we;
    logic [8:0]       waddr;
    logic [CNT_W-1:0] wdata;

    logic [WORD_W-1:0] low_reg, low_next, range_reg, range_next;
    logic [CNT_W-1:0]  clo_reg, chi_reg, ctot_reg, prev_reg;
    logic [WORD_W-1:0] rem_reg, quo_reg;
    logic [6:0]        dcnt_reg;
    logic              dbusy_reg;
    logic [7:0]        byte_reg;

    // one table address per command; read data is registered and follows in the next cycle
    are_ram #(.WIDTH(CNT_W), .DEPTH(257)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(cmd.addr), .rdata(rdata)
    );

    logic [WORD_W-1:0] sum_w, x_w;
    logic              agree, under;
    assign sum_w = low_reg + range_reg;
    assign x_w   = low_reg ^ sum_w;
    assign agree = x_w < TOP_LIMIT;
    assign under = range_reg < BOTTOM_LIMIT;

    logic [CNT_W-1:0] half_w;
    assign half_w = rdata >> 1;

    always_comb begin
        we = 1'b0;
        waddr = cmd.addr;
        wdata = rdata;
        unique case (cmd.op)
            OP_CLR_WR: begin
                we = 1'b1;
                wdata = CNT_W'(cmd.addr);
            end
            OP_UPD_WR: begin
                we = 1'b1;
                wdata = rdata + 1'b1;
            end
            OP_HALVE_WR: begin
                we = 1'b1;
                wdata = (half_w <= prev_reg) ? prev_reg + 1'b1 : half_w;
            end
            default: ;
        endcase
    end

    // quotient times a 17-bit count as two 32x17 partial products
    logic [WORD_W-1:0] mcand;
    logic [CNT_W-1:0]  mplier;
    logic [WORD_W+CNT_W-1:0] prod;
    assign mcand  = quo_reg;
    assign mplier = (cmd.op == OP_MUL_LO) ? clo_reg : chi_reg - clo_reg;
    logic [48:0] pp_lo, pp_hi;
    assign pp_lo = mcand[31:0] * mplier;
    assign pp_hi = mcand[63:32] * mplier;
    assign prod = {32'd0, pp_lo} + {pp_hi, 32'd0};

    // a count width below zero is a 64-bit negative width
    logic              hi_below;
    logic [WORD_W-1:0] wrap_fix;
    assign hi_below = chi_reg < clo_reg;
    assign wrap_fix = hi_below ? {quo_reg[WORD_W-CNT_W-1:0], {CNT_W{1'b0}}} : '0;

    always_comb begin
        low_next = low_reg;
        range_next = range_reg;
        unique case (cmd.op)
            OP_CODER_RESET: begin
                low_next = '0;
                range_next = '1;
            end
            OP_MUL_LO: low_next = low_reg + prod[WORD_W-1:0];
            OP_MUL_HI: range_next = prod[WORD_W-1:0] - wrap_fix;
            OP_RENORM: begin
                if (under && !agree) begin
                    range_next = ((0 - low_reg) & (BOTTOM_LIMIT - 1'b1)) << 8;
                end else begin
                    range_next = range_reg << 8;
                end
                low_next = low_reg << 8;
            end
            OP_FLUSH_BYTE: begin
                low_next = low_reg << 8;
                if (cmd.last_flag) begin
                    range_next = '1;
                end
            end
            default: ;
        endcase
    end

    // restoring divider, one quotient bit per cycle
    logic [WORD_W:0]   trial;
    logic [CNT_W-1:0]  divisor;
    assign divisor = (ctot_reg == '0) ? CNT_W'(1) : ctot_reg;
    assign trial = {rem_reg, quo_reg[WORD_W-1]} - {{(WORD_W-CNT_W+1){1'b0}}, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg <= '0;
            range_reg <= '1;
            dbusy_reg <= 1'b0;
            dcnt_reg <= '0;
        end else begin
            low_reg <= low_next;
            range_reg <= range_next;
            if (cmd.op == OP_DIV_START) begin
                dbusy_reg <= 1'b1;
                dcnt_reg <= '0;
                rem_reg <= '0;
                quo_reg <= range_reg;
            end else if (dbusy_reg) begin
                if (!trial[WORD_W]) begin
                    rem_reg <= trial[WORD_W-1:0];
                    quo_reg <= {quo_reg[WORD_W-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[WORD_W-2:0], quo_reg[WORD_W-1]};
                    quo_reg <= {quo_reg[WORD_W-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg + 1'b1;
                if (dcnt_reg == 7'(WORD_W - 1)) begin
                    dbusy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_RD_HI:    clo_reg <= rdata;
            OP_RD_TOT:   chi_reg <= rdata;
            // entry zero always holds zero
            OP_HALVE_RD: prev_reg <= '0;
            default: ;
        endcase
        if (cmd.op == OP_DIV_START) begin
            ctot_reg <= rdata;
        end
        if (cmd.op == OP_UPD_RD) begin
            ctot_reg <= rdata;
        end
        if (cmd.op == OP_HALVE_WR) begin
            prev_reg <= wdata;
        end
        if (cmd.op == OP_RENORM) begin
            byte_reg <= low_reg[WORD_W-1 -: 8];
        end
    end

    logic div_done_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_done_reg <= 1'b0;
        end else begin
            div_done_reg <= dbusy_reg && dcnt_reg == 7'(WORD_W - 1);
        end
    end

    assign stat.div_done    = div_done_reg;
    assign stat.renorm_go   = agree || under;
    assign stat.total_full  = rdata >= CNT_W'(65536);
    assign stat.prev_ge_tot = 1'b0;
    // flush bytes come straight from low, renorm bytes from the staging register
    assign byte_out = (cmd.op == OP_FLUSH_BYTE) ? low_reg[WORD_W-1 -: 8] : byte_reg;
endmodule

// ===== hdl/are_ctrl.sv =====
`timescale 1ns / 1ps
module are_ctrl
    import are_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_cmd,
    input  logic [7:0] in_sym,
    input  logic [8:0] asize,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd,
    output logic       out_push,
    input  logic       out_free
);
    state_t     state_reg, state_next;
    logic [8:0] idx_reg, idx_next;
    logic [7:0] sym_reg, sym_next;
    logic [3:0] n_reg, n_next;
    logic       setup_reg, setup_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            idx_reg <= '0;
            n_reg <= '0;
            sym_reg <= '0;
            setup_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            n_reg <= n_next;
            sym_reg <= sym_next;
            setup_reg <= setup_next;
        end
    end

    logic [8:0] clr_end;
    assign clr_end = setup_reg ? 9'd256 : asize;

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        n_next = n_reg;
        sym_next = sym_reg;
        setup_next = setup_reg;
        cmd = '{op: OP_IDLE, addr: '0, last_flag: 1'b0};
        in_ready = 1'b0;
        out_push = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    sym_next = in_sym;
                    idx_next = '0;
                    n_next = '0;
                    unique case (cmd_t'(in_cmd))
                        CMD_ENCODE: if ({1'b0, in_sym} < asize) state_next = ST_RD_LO;
                        CMD_FLUSH:  state_next = ST_FLUSH_OUT;
                        CMD_CLEAR: begin
                            cmd.op = OP_CODER_RESET;
                            state_next = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLEAR: begin
                cmd.op = OP_CLR_WR;
                cmd.addr = idx_reg;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == clr_end) begin
                    setup_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_RD_LO: begin
                cmd.op = OP_RD_LO;
                cmd.addr = {1'b0, sym_reg};
                state_next = ST_RD_HI;
            end
            ST_RD_HI: begin
                cmd.op = OP_RD_HI;
                cmd.addr = {1'b0, sym_reg} + 1'b1;
                state_next = ST_RD_TOT;
            end
            ST_RD_TOT: begin
                cmd.op = OP_RD_TOT;
                cmd.addr = asize;
                state_next = ST_WAIT_TOT;
            end
            ST_WAIT_TOT: begin
                cmd.op = OP_DIV_START;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_done) state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                cmd.op = OP_MUL_LO;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.op = OP_MUL_HI;
                state_next = ST_RENORM_CHK;
            end
            ST_RENORM_CHK: begin
                if (stat.renorm_go && n_reg != 4'(MAX_BYTES)) begin
                    if (out_free) begin
                        cmd.op = OP_RENORM;
                        state_next = ST_RENORM_OUT;
                        n_next = n_reg + 1'b1;
                    end
                end else begin
                    idx_next = {1'b0, sym_reg} + 1'b1;
                    state_next = ST_UPD_RD;
                end
            end
            ST_RENORM_OUT: begin
                // last is known once the next check fails; hold the byte
                if (!(stat.renorm_go && n_reg != 4'(MAX_BYTES))) begin
                    if (out_free) begin
                        out_push = 1'b1;
                        cmd.last_flag = 1'b1;
                        idx_next = {1'b0, sym_reg} + 1'b1;
                        state_next = ST_UPD_RD;
                    end
                end else if (out_free) begin
                    out_push = 1'b1;
                    cmd.op = OP_RENORM;
                    n_next = n_reg + 1'b1;
                end
            end
            ST_UPD_RD: begin
                if (idx_reg > asize) begin
                    state_next = ST_TOT_RD;
                end else begin
                    cmd.op = OP_UPD_RD;
                    cmd.addr = idx_reg;
                    state_next = ST_UPD_WR;
                end
            end
            ST_UPD_WR: begin
                cmd.op = OP_UPD_WR;
                cmd.addr = idx_reg;
                idx_next = idx_reg + 1'b1;
                state_next = ST_UPD_RD;
            end
            ST_TOT_RD: begin
                cmd.op = OP_RD_LO;
                cmd.addr = asize;
                state_next = ST_TOT_WAIT;
            end
            ST_TOT_WAIT: begin
                if (stat.total_full) begin
                    cmd.op = OP_HALVE_RD;
                    cmd.addr = '0;
                    idx_next = 9'd1;
                    state_next = ST_HALVE_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_HALVE_RD: begin
                if (idx_reg > asize) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.op = OP_RD_LO;
                    cmd.addr = idx_reg;
                    state_next = ST_HALVE_WR;
                end
            end
            ST_HALVE_WR: begin
                cmd.op = OP_HALVE_WR;
                cmd.addr = idx_reg;
                idx_next = idx_reg + 1'b1;
                state_next = ST_HALVE_RD;
            end
            ST_FLUSH_OUT: begin
                if (out_free) begin
                    cmd.op = OP_FLUSH_BYTE;
                    cmd.last_flag = (n_reg == 4'd7);
                    out_push = 1'b1;
                    n_next = n_reg + 1'b1;
                    if (n_reg == 4'd7) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_IDLE && in_valid && cmd_t'(in_cmd) == CMD_FLUSH) begin
            state_next = ST_FLUSH_OUT;
        end
    end
endmodule

// ===== hdl/adaptive_range_encoder_top.sv =====
`timescale 1ns / 1ps
// adaptive range encoder, carryless 64-bit coder with adaptive order-0 model
// input channel s_axis_*: one transfer per command
//   tdata[7:0] symbol, tuser[1:0] command (0 encode, 1 flush, 2 clear)
// output channel m_axis_*: one transfer per emitted byte, tlast on the final
//   byte of each command; commands that emit nothing give no transfer
// cfg_we / cfg_wdata write alphabet_size (saturated to 1..256) while idle
// one command is processed at a time; tready is high only when idle
// encode: table reads, the restoring divider, two multiply steps, renorm of
//   k bytes, an update of each count above the symbol, a total check, and
//   when the total hits 65536 a halving walk over the table entries; the
//   coder also waits out any output stalls
// flush: eight bytes taken from the top of low, plus output stalls
// clear: a sweep over entries 0..alphabet_size; out-of-alphabet encode or unused command: no work
// reset: a sweep over entries 0..256 loads the identity table; no input is taken
// a one-entry output register holds each byte; when the receiver stalls the
//   coder waits on that register and holds its state
module adaptive_range_encoder_top
    import are_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast    // last
);
    logic [8:0] asize_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            asize_reg <= 9'd256;
        end else if (cfg_we) begin
            if (cfg_wdata == '0) asize_reg <= 9'd1;
            else if (cfg_wdata > 9'd256) asize_reg <= 9'd256;
            else asize_reg <= cfg_wdata;
        end
    end

    dp_cmd_t    cmd;
    dp_stat_t   stat;
    logic       push, out_free;
    logic [7:0] byte_w;

    are_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_cmd(s_axis_tuser), .in_sym(s_axis_tdata), .asize(asize_reg),
        .stat(stat), .cmd(cmd), .out_push(push), .out_free(out_free)
    );

    are_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .stat(stat), .byte_out(byte_w)
    );

    // output register; a push is only issued when it is free or draining
    logic       vld_reg;
    logic [7:0] dat_reg;
    logic       lst_reg;
    assign out_free = !vld_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (push) begin
            vld_reg <= 1'b1;
            dat_reg <= byte_w;
            lst_reg <= cmd.last_flag;
        end else if (m_axis_tready) begin
            vld_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = vld_reg;
    assign m_axis_tdata  = dat_reg;
    assign m_axis_tlast  = lst_reg;
endmodule

// ===== hdl/are_checker.sv =====
`timescale 1ns / 1ps
module are_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);
    // stalled output transfer holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    // no new command taken while an output transfer is being produced
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !(m_axis_tvalid && !m_axis_tready && !m_axis_tlast))
        else $error("input taken mid output");
    // after an accepted command; holds trivially, as $past(s_axis_tready) is then true
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready || !s_axis_tvalid
            || $past(s_axis_tready))
        else $error("handshake inconsistent");
endmodule

bind adaptive_range_encoder_top are_checker u_chk (.*);

// ===== verif/adaptive_range_encoder_checker.sv =====
`timescale 1ns / 1ps
module adaptive_range_encoder_checker
    import are_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending_bytes
);
    typedef struct packed {
        logic [7:0] code_byte;
        logic       final_byte;
    } coded_byte_t;

    logic [63:0]      coder_low;
    logic [63:0]      coder_range;
    logic [CNT_W-1:0] cum_freq [0:256];
    int unsigned      n_symbols;
    coded_byte_t      coded_q [$];

    assign pending_bytes = coded_q.size();

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic void queue_byte(input logic [7:0] b, input logic f);
        coded_byte_t cb;
        cb.code_byte = b;
        cb.final_byte = f;
        coded_q.insert(coded_q.size(), cb);
    endfunction

    function automatic void reset_coder();
        coder_low = '0;
        coder_range = '1;
    endfunction

    function automatic void halve_table();
        logic [CNT_W-1:0] v;
        for (int i = 1; i <= n_symbols; i++) begin
            v = cum_freq[i] >> 1;
            if (v <= cum_freq[i-1]) v = cum_freq[i-1] + 1'b1;
            cum_freq[i] = v;
        end
    endfunction

    function automatic void encode_symbol(input int unsigned sym);
        logic [63:0] total, lo, hi;
        int n;
        total = 64'(cum_freq[n_symbols]);
        lo = 64'(cum_freq[sym]);
        hi = 64'(cum_freq[sym+1]);
        n = 0;
        if (total == 0) total = 1;
        coder_range = coder_range / total;
        coder_low = coder_low + lo * coder_range;
        coder_range = coder_range * (hi - lo);
        while (n < MAX_BYTES && (((coder_low ^ (coder_low + coder_range)) < TOP_LIMIT)
               || coder_range < BOTTOM_LIMIT)) begin
            if (coder_range < BOTTOM_LIMIT
                && (coder_low ^ (coder_low + coder_range)) >= TOP_LIMIT)
                coder_range = (64'd0 - coder_low) & (BOTTOM_LIMIT - 1);
            queue_byte(coder_low[63:56], 1'b0);
            coder_range = coder_range << 8;
            coder_low = coder_low << 8;
            n++;
        end
        if (n > 0) coded_q[$].final_byte = 1'b1;
        for (int i = sym + 1; i <= n_symbols; i++) cum_freq[i] = cum_freq[i] + 1'b1;
        if (cum_freq[n_symbols] >= CNT_W'(0) && 32'(cum_freq[n_symbols]) >= 65536)
            halve_table();
    endfunction

    function automatic void predict(input cmd_t cmd, input logic [7:0] sym);
        case (cmd)
            CMD_ENCODE: begin
                if (sym < n_symbols) encode_symbol(sym);
            end
            CMD_FLUSH: begin
                for (int i = 0; i < 8; i++) begin
                    queue_byte(coder_low[63:56], i == 7);
                    coder_low = coder_low << 8;
                end
                reset_coder();
            end
            CMD_CLEAR: begin
                reset_coder();
                for (int i = 0; i <= n_symbols; i++) cum_freq[i] = CNT_W'(i);
            end
            default: ;
        endcase
    endfunction

    initial fail_count = 0;

    always @(posedge aclk) begin
        coded_byte_t exp_b;
        if (!aresetn) begin
            reset_coder();
            for (int i = 0; i <= 256; i++) cum_freq[i] = CNT_W'(i);
            n_symbols = 256;
            coded_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (coded_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h", m_axis_tdata));
                end else begin
                    exp_b = coded_q.pop_front();
                    if (m_axis_tdata !== exp_b.code_byte)
                        report_mismatch($sformatf("byte %02h, want %02h",
                                                  m_axis_tdata, exp_b.code_byte));
                    if (m_axis_tlast !== exp_b.final_byte)
                        report_mismatch($sformatf("tlast %b, want %b",
                                                  m_axis_tlast, exp_b.final_byte));
                end
            end
            if (cfg_we)
                n_symbols = (cfg_wdata == 0) ? 1 : (cfg_wdata > 256) ? 256 : cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                predict(cmd_t'(s_axis_tuser), s_axis_tdata);
        end
    end
endmodule

// ===== verif/adaptive_range_encoder_top_tb.sv =====
`timescale 1ns / 1ps
module adaptive_range_encoder_top_tb;
    import are_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic [8:0] cfg_wdata = '0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    int         fail_count;
    int         pending_bytes;
    int         alphabet;       // alphabet size last written
    bit         busy_idling = 1'b1;
    int         idle_cycles = 0;

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    adaptive_range_encoder_top uut (.*);

    adaptive_range_encoder_checker checker_i (.*);

    // watchdog: cycles with no transfer on either channel and no config write
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("** adaptive_range_encoder_top: FAILED **");
            $finish;
        end
    end

    // receiver: stalls about 22% of cycles except in the phase with no idling
    always @(negedge aclk) begin
        m_axis_tready <= busy_idling ? ($urandom_range(99) >= 22) : 1'b1;
    end

    // send one command, random gap first, wait for the transfer
    task automatic send_item(input cmd_t cmd, input logic [7:0] sym);
        while (busy_idling && $urandom_range(99) < 22) @(negedge aclk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = cmd;
        s_axis_tdata = sym;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
    endtask

    // drain results and let a silent command finish before touching config
    task automatic wait_idle();
        while (pending_bytes != 0) @(negedge aclk);
        repeat (1200) @(negedge aclk);
    endtask

    // config write followed by clear, as the alphabet change requires
    task automatic set_alphabet(input logic [8:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        alphabet = (value == 0) ? 1 : (value > 256) ? 256 : value;
        send_item(CMD_CLEAR, 8'($urandom));
    endtask

    // skewed symbol: frequent low values drive the counts toward halving
    function automatic logic [7:0] pick_symbol();
        if ($urandom_range(9) == 0) return 8'($urandom);
        if ($urandom_range(1)) return 8'($urandom_range(alphabet > 4 ? 3 : alphabet - 1));
        return 8'($urandom_range(alphabet - 1));
    endfunction

    initial begin
        int r;
        alphabet = 256;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every command, out-of-alphabet and unused command
        send_item(CMD_ENCODE, 8'd0);
        send_item(CMD_ENCODE, 8'd255);
        send_item(CMD_ENCODE, 8'hAA);
        send_item(CMD_ENCODE, 8'h55);
        send_item(CMD_NONE, 8'hFF);
        send_item(CMD_FLUSH, 8'd0);
        send_item(CMD_CLEAR, 8'd0);
        set_alphabet(9'd0);                 // saturates to 1
        send_item(CMD_ENCODE, 8'd0);
        send_item(CMD_ENCODE, 8'd1);
        send_item(CMD_FLUSH, 8'd0);
        set_alphabet(9'h1FF);               // saturates to 256
        send_item(CMD_ENCODE, 8'd255);
        set_alphabet(9'd2);
        for (int i = 0; i < 6; i++) send_item(CMD_ENCODE, 8'(i & 1));
        send_item(CMD_ENCODE, 8'd2);
        send_item(CMD_FLUSH, 8'd0);

        // sender pauses until every byte is back
        wait_idle();

        // random phases over several alphabet sizes, one with no idling
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_alphabet(9'd256);
                1: set_alphabet(9'd3);
                2: set_alphabet(9'($urandom_range(4, 200)));
                3: set_alphabet(9'd1);
                default: set_alphabet(9'd256);
            endcase
            busy_idling = (ph != 3);
            for (int k = 0; k < 36; k++) begin
                r = $urandom_range(99);
                if (r < 84) send_item(CMD_ENCODE, pick_symbol());
                else if (r < 93) send_item(CMD_FLUSH, 8'($urandom));
                else if (r < 97) send_item(CMD_CLEAR, 8'($urandom));
                else send_item(CMD_NONE, 8'($urandom));
            end
            busy_idling = 1'b1;
            send_item(CMD_FLUSH, 8'd0);
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("** adaptive_range_encoder_top: PASSED **");
        end else begin
            $display("** adaptive_range_encoder_top: FAILED **");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/are_pkg.sv
hdl/are_ram.sv
hdl/are_datapath.sv
hdl/are_ctrl.sv
hdl/adaptive_range_encoder_top.sv
hdl/are_checker.sv
verif/adaptive_range_encoder_checker.sv
verif/adaptive_range_encoder_top_tb.sv
